### sv/tlnt_pkg.sv
`default_nettype none
package tlnt_pkg;

    // Telnet command and option codes.
    localparam logic [7:0] T_IAC  = 8'd255;
    localparam logic [7:0] T_DONT = 8'd254;
    localparam logic [7:0] T_DO   = 8'd253;
    localparam logic [7:0] T_WONT = 8'd252;
    localparam logic [7:0] T_WILL = 8'd251;
    localparam logic [7:0] T_SB   = 8'd250;
    localparam logic [7:0] T_DM   = 8'd242;
    localparam logic [7:0] T_SE   = 8'd240;

    localparam logic [7:0] OPT_ECHO  = 8'd1;
    localparam logic [7:0] OPT_SGA   = 8'd3;
    localparam logic [7:0] OPT_TTYPE = 8'd24;
    localparam logic [7:0] Q_IS      = 8'd0;
    localparam logic [7:0] Q_SEND    = 8'd1;

    // Screen sizes that select a terminal type suffix.
    localparam logic [7:0] ROWS_M = 8'd32;
    localparam logic [7:0] COLS_M = 8'd102;
    localparam logic [7:0] ROWS_W = 8'd43;
    localparam logic [7:0] COLS_W = 8'd132;

    localparam logic [7:0] ROWS_RESET = 8'd24;
    localparam logic [7:0] COLS_RESET = 8'd80;

    // Result destinations.
    localparam logic [1:0] DEST_TERM  = 2'd0;
    localparam logic [1:0] DEST_HOST  = 2'd1;
    localparam logic [1:0] DEST_FLUSH = 2'd2;

    // Job kinds handed from the parser to the emitter.
    localparam logic [1:0] JOB_SINGLE = 2'd0;
    localparam logic [1:0] JOB_REPLY3 = 2'd1;
    localparam logic [1:0] JOB_TTYPE  = 2'd2;

    // Terminal type suffix.
    localparam logic [1:0] SFX_NONE = 2'd0;
    localparam logic [1:0] SFX_M    = 2'd1;
    localparam logic [1:0] SFX_W    = 2'd2;

    // Configuration register indexes.
    localparam logic REG_ROWS = 1'b0;
    localparam logic REG_COLS = 1'b1;

    localparam int QUEUE_DEPTH_DEF = 4;

    typedef struct packed {
        logic [1:0] kind;
        logic [1:0] dest;
        logic [7:0] b0;
        logic [7:0] b1;
        logic [1:0] suffix;
        logic       echo;
    } t_job;

endpackage
`default_nettype wire

### sv/telnet_receive_decoder.sv
`default_nettype none
// Telnet receive decoder.
// Input channel (i_rx_valid, o_rx_ready, i_rx_byte) takes one received byte per
// word. Output channel (o_valid, i_ready, o_dest, o_value, o_last, o_echo_mode)
// delivers the terminal bytes, host reply bytes and flush events that each
// byte causes; o_last marks the final word for one input byte.
// The parser takes a byte every cycle while its job queue has room. A byte that
// yields a result is queued and then registered into the output word. The
// emitter sends one word per cycle while i_ready lets it: data and flush events
// are one word, option replies three, a terminal type reply ten or twelve, so
// the emitter's position counter sets the sustained rate when replies pile up.
// The queue holds QUEUE_DEPTH jobs; when it is full o_rx_ready drops.
// When the receiver holds i_ready low the output word waits, the emitter
// stops, and the queue fills before input is refused.
// Synchronous reset returns the parser to the data state, clears the echo
// flag, empties the queue and restores 24 rows by 80 columns.
// Registers over APB: screen_rows at byte address 0, screen_cols at 4.
module telnet_receive_decoder #(
    parameter int QUEUE_DEPTH = tlnt_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_rx_valid,
    output logic             o_rx_ready,
    input  wire logic [7:0]  i_rx_byte,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [1:0]       o_dest,
    output logic [7:0]       o_value,
    output logic             o_last,
    output logic             o_echo_mode,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    import tlnt_pkg::*;

    logic [7:0] r_rows, r_cols;
    logic       push, pop, full, empty;
    t_job       job_in, job_out;

    assign pready = 1'b1;
    assign prdata = {24'd0, (paddr[2] == REG_COLS) ? r_cols : r_rows};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows <= ROWS_RESET;
            r_cols <= COLS_RESET;
        end else if (psel && penable && pwrite) begin
            if (paddr[2] == REG_ROWS) r_rows <= pwdata[7:0];
            else r_cols <= pwdata[7:0];
        end
    end

    tlnt_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rx_valid (i_rx_valid),
        .o_rx_ready (o_rx_ready),
        .i_rx_byte  (i_rx_byte),
        .i_rows     (r_rows),
        .i_cols     (r_cols),
        .i_full     (full),
        .o_push     (push),
        .o_job      (job_in)
    );

    tlnt_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (job_in),
        .o_full  (full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_data  (job_out)
    );

    tlnt_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_empty     (empty),
        .i_job       (job_out),
        .o_pop       (pop),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_dest      (o_dest),
        .o_value     (o_value),
        .o_last      (o_last),
        .o_echo_mode (o_echo_mode)
    );

    // Terminal bytes and flush events always stand alone.
    a_term_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_dest == DEST_TERM) |-> o_last)
        else $error("terminal word without last");

    a_flush_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_dest == DEST_FLUSH) |-> (o_value == 8'd0 && o_last))
        else $error("bad flush word");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_valid && o_rx_ready))
        else $error("not idle after reset");

    // Input is refused only while the queue is full.
    a_ready_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_rx_ready |-> (full && !empty))
        else $error("input refused with room in queue");

endmodule
`default_nettype wire

### sv/tlnt_front.sv
`default_nettype none
module tlnt_front (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_rx_valid,
    output logic                 o_rx_ready,
    input  wire logic [7:0]      i_rx_byte,
    input  wire logic [7:0]      i_rows,
    input  wire logic [7:0]      i_cols,
    input  wire logic            i_full,
    output logic                 o_push,
    output tlnt_pkg::t_job       o_job
);
    import tlnt_pkg::*;

    localparam logic [3:0] PS_DATA   = 4'd0;
    localparam logic [3:0] PS_IAC    = 4'd1;
    localparam logic [3:0] PS_DO     = 4'd2;
    localparam logic [3:0] PS_DONT   = 4'd3;
    localparam logic [3:0] PS_WILL   = 4'd4;
    localparam logic [3:0] PS_WONT   = 4'd5;
    localparam logic [3:0] PS_SB     = 4'd6;
    localparam logic [3:0] PS_SBTT   = 4'd7;
    localparam logic [3:0] PS_WAITI  = 4'd8;
    localparam logic [3:0] PS_WAITSE = 4'd9;

    logic [3:0] r_state, n_state;
    logic       r_echo, n_echo;
    logic       accept;
    logic       emit;
    logic       ok;
    t_job       job;

    assign o_rx_ready = !i_full;
    assign accept     = i_rx_valid && !i_full;

    always_comb begin
        n_state    = r_state;
        n_echo     = r_echo;
        emit       = 1'b0;
        job.kind   = JOB_SINGLE;
        job.dest   = DEST_TERM;
        job.b0     = i_rx_byte;
        job.b1     = i_rx_byte;
        job.suffix = SFX_NONE;
        ok         = i_rx_byte inside {OPT_ECHO, OPT_SGA, OPT_TTYPE};
        case (r_state)
            PS_IAC: begin
                n_state = PS_DATA;
                case (i_rx_byte)
                    T_DO:   n_state = PS_DO;
                    T_DONT: n_state = PS_DONT;
                    T_WILL: n_state = PS_WILL;
                    T_WONT: n_state = PS_WONT;
                    T_SB:   n_state = PS_SB;
                    T_DM: begin
                        emit     = 1'b1;
                        job.dest = DEST_FLUSH;
                        job.b0   = 8'd0;
                    end
                    default: emit = 1'b1;
                endcase
            end
            PS_DO, PS_DONT, PS_WILL, PS_WONT: begin
                emit     = 1'b1;
                job.kind = JOB_REPLY3;
                job.dest = DEST_HOST;
                n_state  = PS_DATA;
                case (r_state)
                    PS_DO: begin
                        job.b0 = ok ? T_WILL : T_WONT;
                        if (ok) n_echo = 1'b1;
                    end
                    PS_WILL: begin
                        job.b0 = ok ? T_DO : T_DONT;
                        if (ok) n_echo = 1'b1;
                    end
                    PS_DONT: begin
                        job.b0 = T_WONT;
                        if (ok) n_echo = 1'b0;
                    end
                    default: begin
                        job.b0 = T_DONT;
                        if (ok) n_echo = 1'b0;
                    end
                endcase
            end
            PS_SB: begin
                if (i_rx_byte == OPT_TTYPE) n_state = PS_SBTT;
            end
            PS_SBTT: begin
                if (i_rx_byte == Q_SEND) begin
                    emit     = 1'b1;
                    job.kind = JOB_TTYPE;
                    job.dest = DEST_HOST;
                    n_state  = PS_WAITI;
                    if (i_rows == ROWS_M && i_cols == COLS_M) begin
                        job.suffix = SFX_M;
                    end else if (i_rows == ROWS_W && i_cols == COLS_W) begin
                        job.suffix = SFX_W;
                    end
                end
            end
            PS_WAITI: begin
                if (i_rx_byte == T_IAC) n_state = PS_WAITSE;
            end
            PS_WAITSE: n_state = PS_DATA;
            default: begin
                n_state = PS_DATA;
                if (i_rx_byte == T_IAC) begin
                    n_state = PS_IAC;
                end else begin
                    emit = 1'b1;
                end
            end
        endcase
        job.echo = n_echo;
    end

    assign o_push = accept && emit;
    assign o_job  = job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= PS_DATA;
            r_echo  <= 1'b0;
        end else if (accept) begin
            r_state <= n_state;
            r_echo  <= n_echo;
        end
    end

endmodule
`default_nettype wire

### sv/tlnt_queue.sv
`default_nettype none
module tlnt_queue #(
    parameter int DEPTH = tlnt_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_push,
    input  wire tlnt_pkg::t_job  i_data,
    output logic                 o_full,
    input  wire logic            i_pop,
    output logic                 o_empty,
    output tlnt_pkg::t_job       o_data
);
    import tlnt_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_job          r_mem [DEPTH];
    logic [AW-1:0] r_wr, r_rd;
    logic [CW-1:0] r_count;

    function automatic logic [AW-1:0] bump(input logic [AW-1:0] p);
        logic [AW-1:0] q;
        if (p == AW'(DEPTH - 1)) q = '0;
        else q = p + AW'(1);
        return q;
    endfunction

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr] <= i_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) r_wr <= bump(r_wr);
            if (i_pop)  r_rd <= bump(r_rd);
            if (i_push && !i_pop) r_count <= r_count + CW'(1);
            else if (!i_push && i_pop) r_count <= r_count - CW'(1);
        end
    end

endmodule
`default_nettype wire

### sv/tlnt_back.sv
`default_nettype none
module tlnt_back (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_empty,
    input  wire tlnt_pkg::t_job  i_job,
    output logic                 o_pop,
    output logic                 o_valid,
    input  wire logic            i_ready,
    output logic [1:0]           o_dest,
    output logic [7:0]           o_value,
    output logic                 o_last,
    output logic                 o_echo_mode
);
    import tlnt_pkg::*;

    logic [3:0] r_idx;
    logic [3:0] len;
    logic [1:0] dest;
    logic [7:0] val;
    logic       load;
    logic       fin;
    logic       r_valid;
    logic [1:0] r_dest;
    logic [7:0] r_value;
    logic       r_last;
    logic       r_echo;

    // Byte at position r_idx of the current job.
    always_comb begin
        dest = DEST_HOST;
        val  = T_IAC;
        len  = 4'd1;
        case (i_job.kind)
            JOB_REPLY3: begin
                len = 4'd3;
                case (r_idx)
                    4'd0:    val = T_IAC;
                    4'd1:    val = i_job.b0;
                    default: val = i_job.b1;
                endcase
            end
            JOB_TTYPE: begin
                len = (i_job.suffix == SFX_NONE) ? 4'd10 : 4'd12;
                case (r_idx)
                    4'd0: val = T_IAC;
                    4'd1: val = T_SB;
                    4'd2: val = OPT_TTYPE;
                    4'd3: val = Q_IS;
                    4'd4: val = 8'h61;
                    4'd5: val = 8'h6e;
                    4'd6: val = 8'h73;
                    4'd7: val = 8'h69;
                    4'd8: val = (i_job.suffix == SFX_NONE) ? T_IAC : 8'h2d;
                    4'd9: begin
                        case (i_job.suffix)
                            SFX_M:   val = 8'h6d;
                            SFX_W:   val = 8'h77;
                            default: val = T_SE;
                        endcase
                    end
                    4'd10:   val = T_IAC;
                    default: val = T_SE;
                endcase
            end
            default: begin
                dest = i_job.dest;
                val  = i_job.b0;
            end
        endcase
    end

    assign load  = !i_empty && (!r_valid || i_ready);
    assign fin   = (r_idx == len - 4'd1);
    assign o_pop = load && fin;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= '0;
            r_valid <= 1'b0;
        end else begin
            if (load) begin
                r_idx   <= fin ? 4'd0 : r_idx + 4'd1;
                r_valid <= 1'b1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_dest  <= dest;
            r_value <= val;
            r_last  <= fin;
            r_echo  <= i_job.echo;
        end
    end

    assign o_valid     = r_valid;
    assign o_dest      = r_dest;
    assign o_value     = r_value;
    assign o_last      = r_last;
    assign o_echo_mode = r_echo;

endmodule
`default_nettype wire
